// ===== rtl/core/drc_pkg.sv =====
// Shared constants and types of the dense rank compression core.
`default_nettype none

package drc_pkg;

    // Store depth and the widths that follow from it.
    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Fixed field widths of the request and result channels.
    localparam int VAL_W  = 32;
    localparam int RANK_W = 7;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY,
        ST_KEYW,
        ST_SCAN,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/drc_if.sv =====
// Valid/ready channel interfaces for value requests and rank results.
`default_nettype none

interface drc_in_if;
    import drc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] value;
    logic                    last_value;

    modport source (output valid, output value, output last_value, input ready);
    modport sink   (input valid, input value, input last_value, output ready);
endinterface

interface drc_out_if;
    import drc_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank;
    logic              last_rank;
    logic              truncated;

    modport source (output valid, output rank, output last_rank, output truncated,
                    input ready);
    modport sink   (input valid, input rank, input last_rank, input truncated,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dense_rank_compression_core.sv =====
// Top level of the dense rank compression core.
`default_nettype none

// Values of a set are taken one per cycle and written into a 64-entry value
// RAM while i_in.ready is high. The request marked last_value, or the request
// that fills the store, ends the set; that set then carries truncated = 1 on
// all its results unless the filling request was also marked last. The block
// then drops ready and ranks the set with a single comparator that reads the
// RAM through its one read port, one stored value per cycle: a first pass marks
// repeated values and a second pass counts, for each value, the distinct
// smaller ones. Each rank is presented as soon as its count is done and must
// be taken before the next one is counted. The time a set takes after its
// final request is bounded by the shared comparator and the RAM read port,
// and a result that waits delays the rest of the set. There is no clearing
// pass after reset.
module dense_rank_compression_core (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    drc_in_if.sink    i_in,
    drc_out_if.source o_out
);
    import drc_pkg::*;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_n, n_n;
    logic                    r_cut, n_cut;
    logic                    r_rank_ph, n_rank_ph;
    logic [CNT_W-1:0]        r_i, n_i;
    logic [CNT_W-1:0]        r_j, n_j;
    logic                    r_pend, n_pend;
    logic [IDX_W-1:0]        r_pj, n_pj;
    logic signed [VAL_W-1:0] r_key, n_key;
    logic [RANK_W-1:0]       r_cnt, n_cnt;
    logic [MAX_ITEMS-1:0]    r_dup, n_dup;

    logic             in_acc;
    logic             out_acc;
    logic             set_end;
    logic [CNT_W-1:0] scan_end;
    logic             issue;
    logic             scan_done;
    logic [IDX_W-1:0] rd_addr;
    logic [VAL_W-1:0] rd_data;
    logic             cmp_eq;
    logic             cmp_lt;

    // Value store.
    drc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Handshake and scan control terms.
    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = o_out.valid && o_out.ready;
    assign set_end   = i_in.last_value || (r_count == CNT_W'(MAX_ITEMS - 1));
    assign scan_end  = r_rank_ph ? r_n : r_i;
    assign issue     = (r_state == ST_SCAN) && (r_j < scan_end);
    assign scan_done = (r_state == ST_SCAN) && !issue && !r_pend;
    assign rd_addr   = (r_state == ST_KEY) ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];

    // The shared comparator: equality and signed order against the key.
    assign cmp_eq = (rd_data == r_key);
    assign cmp_lt = ($signed(rd_data) < r_key);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc && set_end) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY:  n_state = ST_KEYW;
            ST_KEYW: n_state = ST_SCAN;
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = r_rank_ph ? ST_OUT : ST_KEY;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_state = (r_i == r_n - CNT_W'(1)) ? ST_LOAD : ST_KEY;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Channel outputs.
    always_comb begin
        i_in.ready      = (r_state == ST_LOAD);
        o_out.valid     = (r_state == ST_OUT);
        o_out.rank      = r_cnt;
        o_out.last_rank = (r_i == r_n - CNT_W'(1));
        o_out.truncated = r_cut;
    end

    // Datapath next values.
    always_comb begin
        n_count   = r_count;
        n_n       = r_n;
        n_cut     = r_cut;
        n_rank_ph = r_rank_ph;
        n_i       = r_i;
        n_j       = r_j;
        n_pend    = r_pend;
        n_pj      = r_pj;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_dup     = r_dup;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (set_end) begin
                        n_count   = '0;
                        n_n       = r_count + CNT_W'(1);
                        n_cut     = !i_in.last_value;
                        n_rank_ph = 1'b0;
                        n_i       = '0;
                        n_dup     = '0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_KEY: begin
                n_pend = 1'b0;
            end
            ST_KEYW: begin
                n_key  = $signed(rd_data);
                n_j    = '0;
                n_pend = 1'b0;
                n_cnt  = RANK_W'(1);
            end
            ST_SCAN: begin
                // Issue the next read while the previous one is compared.
                if (issue) begin
                    n_j = r_j + CNT_W'(1);
                end
                n_pend = issue;
                n_pj   = r_j[IDX_W-1:0];
                if (r_pend) begin
                    if (r_rank_ph) begin
                        if (!r_dup[r_pj] && cmp_lt) begin
                            n_cnt = r_cnt + RANK_W'(1);
                        end
                    end else if (cmp_eq) begin
                        n_dup[r_i[IDX_W-1:0]] = 1'b1;
                    end
                end
                // The repeat-marking pass moves to the ranking pass at its end.
                if (scan_done && !r_rank_ph) begin
                    if (r_i + CNT_W'(1) == r_n) begin
                        n_rank_ph = 1'b1;
                        n_i       = '0;
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_i = r_i + CNT_W'(1);
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_n       <= '0;
            r_cut     <= 1'b0;
            r_rank_ph <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_pend    <= 1'b0;
            r_dup     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_n       <= n_n;
            r_cut     <= n_cut;
            r_rank_ph <= n_rank_ph;
            r_i       <= n_i;
            r_j       <= n_j;
            r_pend    <= n_pend;
            r_dup     <= n_dup;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pj  <= n_pj;
        r_key <= n_key;
        r_cnt <= n_cnt;
    end

endmodule

`default_nettype wire

// ===== rtl/core/drc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module drc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/drc_checker.sv =====
// Port-level checks of the dense rank compression core, bound to the top level.
`default_nettype none

module drc_checker (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    drc_in_if.sink    i_in,
    drc_out_if.source o_out
);
    import drc_pkg::*;

    // The block never takes a request while it shows a result.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("request taken while a result is shown");

    // A request that ends a set starts ranking.
    a_last_starts_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_value) |=> !i_in.ready)
        else $error("ready stayed high after the last value of a set");

    // The final result of a set reopens the request channel.
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_rank) |=> i_in.ready)
        else $error("no return to loading after the final rank");

    // Ranks stay within the store depth.
    a_rank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.rank != '0) && (o_out.rank <= RANK_W'(MAX_ITEMS)))
        else $error("rank out of range");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=>
            (o_out.valid && $stable(o_out.rank) && $stable(o_out.last_rank)
             && $stable(o_out.truncated)))
        else $error("stalled result changed");

endmodule

bind dense_rank_compression_core drc_checker u_drc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the dense rank compression core: directed and random sets.
module tb;
    import drc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 470;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 500;
    localparam int DIR_ROWS     = 21;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
        logic              truncated;
    } rank_res_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last_value;
        logic                    typed;
        logic [RANK_W-1:0]       rank;
    } stim_row_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    drc_in_if  in_ch ();
    drc_out_if out_ch ();

    dense_rank_compression_core uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Values of the open set as the predictor sees them.
    logic signed [VAL_W-1:0] set_vals [MAX_ITEMS];
    int                      set_len = 0;
    rank_res_t               pending_ranks [$];

    int err_count     = 0;
    int results_taken = 0;
    int cycle_count   = 0;

    // Directed sets. Single-value sets carry their rank; the rest go to the predictor.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{32'h8000_0000, 1'b1, 1'b1, 7'd1},
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 7'd1},
        '{32'h0000_0000, 1'b1, 1'b1, 7'd1},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 7'd1},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{32'h8000_0000, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0000, 1'b0, 1'b0, 7'd0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0001, 1'b1, 1'b0, 7'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0005, 1'b0, 1'b0, 7'd0},
        '{32'hFFFF_FFFB, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0005, 1'b1, 1'b0, 7'd0},
        '{32'h0000_0007, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0007, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0007, 1'b1, 1'b0, 7'd0},
        '{32'h0000_0003, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0002, 1'b0, 1'b0, 7'd0},
        '{32'h0000_0001, 1'b1, 1'b0, 7'd0},
        '{32'h5555_5555, 1'b0, 1'b0, 7'd0},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 7'd0}
    };

    // Add one value to the open set; when the set ends, queue the rank of every value.
    function automatic void rank_predict(input logic signed [VAL_W-1:0] v, input logic last_v);
        int i;
        int j;
        int k;
        int r;
        bit first;
        set_vals[set_len] = v;
        set_len++;
        if (!last_v && set_len < MAX_ITEMS) return;
        for (i = 0; i < set_len; i++) begin
            r = 1;
            for (j = 0; j < set_len; j++) begin
                // Count each distinct smaller value once, at its first entry.
                first = 1'b1;
                for (k = 0; k < j; k++) begin
                    if (set_vals[k] == set_vals[j]) first = 1'b0;
                end
                if (first && set_vals[j] < set_vals[i]) r++;
            end
            pending_ranks.push_back('{RANK_W'(r), (i == set_len - 1), !last_v});
        end
        set_len = 0;
    endfunction

    // Mostly back-to-back requests, some short gaps and a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values that favor repeats and extremes, with full-width noise mixed in.
    function automatic logic signed [VAL_W-1:0] rand_value();
        int r;
        int s;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            s = $urandom_range(0, 8);
            return VAL_W'(s - 4);
        end
        if (r < 6) begin
            case ($urandom_range(0, 5))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                3: return '1;
                4: return VAL_MIN + 1;
                default: return VAL_MAX - 1;
            endcase
        end
        return $urandom;
    endfunction

    // Offer one request and hold it until accepted. Called and returns at a falling edge.
    task automatic send_value(input logic signed [VAL_W-1:0] v, input logic last_v,
                              input int gap, input bit typed, input rank_res_t typed_res);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.value      <= v;
        in_ch.last_value <= last_v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (typed) begin
            pending_ranks.push_back(typed_res);
            set_len = 0;
        end else begin
            rank_predict(v, last_v);
        end
        @(negedge i_clk);
    endtask

    // Request side: reset, directed sets, then random sets.
    initial begin
        int row;
        int len;
        int k;
        int r;
        int n_sent;
        int set_idx;
        bit cut;
        bit no_gap;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.last_value = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < DIR_ROWS; row++) begin
            send_value(dir_rows[row].value, dir_rows[row].last_value, pick_gap(),
                       dir_rows[row].typed, '{dir_rows[row].rank, 1'b1, 1'b0});
        end

        // The first two random sets fill the store, without and then with a last marker.
        n_sent  = 0;
        set_idx = 0;
        while (n_sent < RANDOM_ITEMS) begin
            cut = 1'b0;
            if (set_idx == 0) begin
                len = MAX_ITEMS;
                cut = 1'b1;
            end else if (set_idx == 1) begin
                len = MAX_ITEMS;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    len = $urandom_range(1, 10);
                end else if (r < 95) begin
                    len = $urandom_range(11, 32);
                end else begin
                    len = MAX_ITEMS;
                    cut = $urandom_range(0, 1);
                end
            end
            no_gap = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++) begin
                send_value(rand_value(), (k == len - 1) && !cut, no_gap ? 0 : pick_gap(),
                           1'b0, '0);
            end
            n_sent += len;
            set_idx++;
        end
        in_ch.valid <= 1'b0;

        // Drain the remaining ranks, then watch for stray results.
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Result side: random stalls, calm stretches, and one long hold-off.
    initial begin
        int stall_left;
        int calm_left;
        int r;
        bit held;
        stall_left   = 0;
        calm_left    = 0;
        held         = 1'b0;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            @(negedge i_clk);
            if (!held && results_taken >= 30) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (calm_left > 0) begin
                out_ch.ready <= 1'b1;
                calm_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    out_ch.ready <= 1'b1;
                    calm_left = $urandom_range(50, 200);
                end else if (r < 24) begin
                    out_ch.ready <= 1'b0;
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                              : $urandom_range(0, 2);
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Compare each accepted rank with the oldest expected one.
    always @(posedge i_clk) begin
        rank_res_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_taken++;
            if (pending_ranks.size() == 0) begin
                $display("%0t: unexpected result rank %0d last %0b truncated %0b", $realtime,
                         out_ch.rank, out_ch.last_rank, out_ch.truncated);
                err_count++;
            end else begin
                want = pending_ranks.pop_front();
                if (out_ch.rank !== want.rank) begin
                    $display("%0t: rank expected %0d actual %0d", $realtime, want.rank,
                             out_ch.rank);
                    err_count++;
                end
                if (out_ch.last_rank !== want.last_rank) begin
                    $display("%0t: last_rank expected %0b actual %0b", $realtime,
                             want.last_rank, out_ch.last_rank);
                    err_count++;
                end
                if (out_ch.truncated !== want.truncated) begin
                    $display("%0t: truncated expected %0b actual %0b", $realtime,
                             want.truncated, out_ch.truncated);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d ranks outstanding", $realtime,
                     pending_ranks.size());
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/core/drc_pkg.sv
rtl/core/drc_if.sv
rtl/core/drc_ram.sv
rtl/core/dense_rank_compression_core.sv
rtl/core/drc_checker.sv
sim/tb.sv
